@@ rtl/assert_macros.svh @@
// assertion macros used by the checker file v2a_checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/v2a_pkg.sv @@
// shared types and constants of the 2d vector fixed-point unit
// no dependencies
package v2a_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int MIN_LEN_W     = 16;
  localparam logic [MIN_LEN_W-1:0] MIN_LEN_RST = 16'd7;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_SCALE = 3'd2,
    OP_DOT   = 3'd3,
    OP_LEN   = 3'd4,
    OP_NORM  = 3'd5,
    OP_CLAMP = 3'd6
  } op_t;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] scalar_in;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] rs;
    logic               saturated;
  } out_beat_t;

endpackage

@@ rtl/v2a_sqrt_cell.sv @@
// one step of the integer square root row: compare, subtract, shift
// depends on nothing outside this file
module v2a_sqrt_cell #(
  parameter int NW      = 64,
  parameter int BIT_POS = 62,
  parameter int SW      = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_v,
  input  logic [NW-1:0] in_n,
  input  logic [NW-1:0] in_res,
  input  logic [SW-1:0] in_side,
  output logic          out_v,
  output logic [NW-1:0] out_n,
  output logic [NW-1:0] out_res,
  output logic [SW-1:0] out_side
);

  localparam logic [NW-1:0] BIT = {{(NW-1){1'b0}}, 1'b1} << BIT_POS;

  logic          v_r;
  logic [NW-1:0] n_r, res_r, n_nxt, res_nxt;
  logic [SW-1:0] side_r;
  logic [NW:0]   trial;
  logic          ge;

  always_comb begin
    trial   = {1'b0, in_res} + {1'b0, BIT};
    ge      = {1'b0, in_n} >= trial;
    n_nxt   = ge ? (in_n - trial[NW-1:0]) : in_n;
    res_nxt = ge ? ((in_res >> 1) + BIT) : (in_res >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r    <= n_nxt;
      res_r  <= res_nxt;
      side_r <= in_side;
    end
  end

  assign out_v    = v_r;
  assign out_n    = n_r;
  assign out_res  = res_r;
  assign out_side = side_r;

endmodule

@@ rtl/v2a_div_cell.sv @@
// one restoring division step for the x and y lanes sharing one divisor
// depends on nothing outside this file
module v2a_div_cell #(
  parameter int NB = 63,
  parameter int DW = 32,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_v,
  input  logic [DW-1:0] in_den,
  input  logic [DW-1:0] in_remx,
  input  logic [NB-1:0] in_nqx,
  input  logic [DW-1:0] in_remy,
  input  logic [NB-1:0] in_nqy,
  input  logic [SW-1:0] in_side,
  output logic          out_v,
  output logic [DW-1:0] out_den,
  output logic [DW-1:0] out_remx,
  output logic [NB-1:0] out_nqx,
  output logic [DW-1:0] out_remy,
  output logic [NB-1:0] out_nqy,
  output logic [SW-1:0] out_side
);

  logic          v_r;
  logic [DW-1:0] den_r, remx_r, remy_r, remx_nxt, remy_nxt;
  logic [NB-1:0] nqx_r, nqy_r, nqx_nxt, nqy_nxt;
  logic [SW-1:0] side_r;
  logic [DW:0]   r2x, r2y, dx, dy;
  logic          gex, gey;

  always_comb begin
    r2x      = {in_remx, in_nqx[NB-1]};
    r2y      = {in_remy, in_nqy[NB-1]};
    gex      = r2x >= {1'b0, in_den};
    gey      = r2y >= {1'b0, in_den};
    dx       = r2x - {1'b0, in_den};
    dy       = r2y - {1'b0, in_den};
    remx_nxt = gex ? dx[DW-1:0] : r2x[DW-1:0];
    remy_nxt = gey ? dy[DW-1:0] : r2y[DW-1:0];
    nqx_nxt  = {in_nqx[NB-2:0], gex};
    nqy_nxt  = {in_nqy[NB-2:0], gey};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r  <= in_den;
      remx_r <= remx_nxt;
      remy_r <= remy_nxt;
      nqx_r  <= nqx_nxt;
      nqy_r  <= nqy_nxt;
      side_r <= in_side;
    end
  end

  assign out_v    = v_r;
  assign out_den  = den_r;
  assign out_remx = remx_r;
  assign out_nqx  = nqx_r;
  assign out_remy = remy_r;
  assign out_nqy  = nqy_r;
  assign out_side = side_r;

endmodule

@@ rtl/vec2_fixed_point_alu_unit.sv @@
// pipeline: operand capture, products, numerators, square root row (IB cells), compare stage,
// divider row (NB cells) and output register, where IB = min(WORD_BITS,32) and
// NB = max(IB + FRAC_BITS, 2*IB - 1); throughput: one beat per cycle unless a held result
// stalls the pipeline, set by the square root and divider rows, both fully pipelined
// reset: synchronous active-low rst_n empties the pipeline and sets min_length to 7
// depends on v2a_pkg, v2a_sqrt_cell and v2a_div_cell
module vec2_fixed_point_alu_unit #(
  parameter int WORD_BITS = v2a_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = v2a_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  v2a_pkg::in_beat_t               in_beat,
  output logic                            out_valid,
  input  logic                            out_ready,
  output v2a_pkg::out_beat_t              out_beat,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [v2a_pkg::MIN_LEN_W-1:0]   cfg_data
);

  localparam int IB = (WORD_BITS < 32) ? WORD_BITS : 32;
  localparam int PW = 2 * IB;
  localparam int NB = (IB + FRAC_BITS > 2 * IB - 1) ? (IB + FRAC_BITS) : (2 * IB - 1);
  localparam int XW = NB + 2;
  localparam int ML = v2a_pkg::MIN_LEN_W;
  localparam logic signed [XW-1:0] RES_MAX =
    {{(XW - WORD_BITS + 1){1'b0}}, {(WORD_BITS - 1){1'b1}}};
  localparam logic signed [XW-1:0] RES_MIN = ~RES_MAX;

  typedef struct packed {
    v2a_pkg::op_t      op;
    logic signed [IB-1:0] s;
    logic [31:0]       rx;
    logic [31:0]       ry;
    logic [31:0]       rs;
    logic              sat;
    logic [NB-1:0]     numx;
    logic [NB-1:0]     numy;
    logic              negx;
    logic              negy;
  } sq_side_t;

  typedef struct packed {
    logic        use_div;
    logic [31:0] rx;
    logic [31:0] ry;
    logic [31:0] rs;
    logic        sat;
    logic        negx;
    logic        negy;
  } dv_side_t;

  localparam int SQ_SW = $bits(sq_side_t);
  localparam int DV_SW = $bits(dv_side_t);

  function automatic logic [XW:0] sat_fn(input logic signed [XW-1:0] v);
    logic [XW:0] r;
    if (v > RES_MAX) begin
      r = {1'b1, RES_MAX};
    end else if (v < RES_MIN) begin
      r = {1'b1, RES_MIN};
    end else begin
      r = {1'b0, v};
    end
    return r;
  endfunction

  logic en;
  logic [ML-1:0] min_len_r;

  // stage 1: operand capture
  logic                 v1_r;
  v2a_pkg::op_t         op1_r;
  logic signed [IB-1:0] ax1_r, ay1_r, bx1_r, by1_r, s1_r;

  // stage 2: products and squares
  logic                 v2_r;
  v2a_pkg::op_t         op2_r;
  logic signed [IB-1:0] ax2_r, ay2_r, bx2_r, by2_r, s2_r;
  logic signed [PW-1:0] p1_r, p2_r;
  logic [PW-1:0]        q1_r, q2_r;
  logic [IB-1:0]        mx1, my1;

  // stage 3: simple results and numerators
  logic                 v3_r;
  logic [PW-1:0]        n3_r;
  sq_side_t             sd3_r, sd3_nxt;

  // square root row
  logic          sq_v   [0:IB];
  logic [PW-1:0] sq_n   [0:IB];
  logic [PW-1:0] sq_res [0:IB];
  logic [SQ_SW-1:0] sq_sd [0:IB];

  // divider row and the compare stage that feeds it
  logic          dv_v    [0:NB];
  logic [IB-1:0] dv_den  [0:NB];
  logic [IB-1:0] dv_remx [0:NB];
  logic [IB-1:0] dv_remy [0:NB];
  logic [NB-1:0] dv_nqx  [0:NB];
  logic [NB-1:0] dv_nqy  [0:NB];
  logic [DV_SW-1:0] dv_sd [0:NB];

  logic                  vl_r;
  logic [IB-1:0]         len_r;
  logic [NB-1:0]         lnx_r, lny_r;
  dv_side_t              dl_r, dl_nxt;
  sq_side_t              sq_end;
  logic [IB-1:0]         len_end;

  // output
  logic                  out_valid_r;
  v2a_pkg::out_beat_t    out_beat_r, fin_nxt;
  dv_side_t              dv_end;

  assign en        = !(dv_v[NB] && out_valid_r && !out_ready);
  assign in_ready  = en;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= v2a_pkg::MIN_LEN_RST;
    end else if (cfg_valid) begin
      min_len_r <= cfg_data;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vl_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      vl_r <= sq_v[IB];
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (en) begin
      op1_r <= v2a_pkg::op_t'(in_beat.req_type);
      ax1_r <= in_beat.ax[IB-1:0];
      ay1_r <= in_beat.ay[IB-1:0];
      bx1_r <= in_beat.bx[IB-1:0];
      by1_r <= in_beat.by[IB-1:0];
      s1_r  <= in_beat.scalar_in[IB-1:0];
    end
  end

  // stage 2
  assign mx1 = ax1_r[IB-1] ? IB'(-ax1_r) : IB'(ax1_r);
  assign my1 = ay1_r[IB-1] ? IB'(-ay1_r) : IB'(ay1_r);

  always_ff @(posedge clk) begin
    if (en) begin
      op2_r <= op1_r;
      ax2_r <= ax1_r;
      ay2_r <= ay1_r;
      bx2_r <= bx1_r;
      by2_r <= by1_r;
      s2_r  <= s1_r;
      p1_r  <= PW'(ax1_r) * PW'((op1_r == v2a_pkg::OP_DOT) ? bx1_r : s1_r);
      p2_r  <= PW'(ay1_r) * PW'((op1_r == v2a_pkg::OP_DOT) ? by1_r : s1_r);
      q1_r  <= PW'(mx1) * PW'(mx1);
      q2_r  <= PW'(my1) * PW'(my1);
    end
  end

  // stage 3
  logic signed [XW-1:0] axw, ayw, bxw, byw, p1w, p2w;
  logic [XW:0]          sx, sy, ss;
  logic [IB-1:0]        mx2, my2;
  logic [PW-1:0]        mp1, mp2;

  always_comb begin
    axw = XW'(ax2_r);
    ayw = XW'(ay2_r);
    bxw = XW'(bx2_r);
    byw = XW'(by2_r);
    p1w = XW'(p1_r);
    p2w = XW'(p2_r);
    mx2 = ax2_r[IB-1] ? IB'(-ax2_r) : IB'(ax2_r);
    my2 = ay2_r[IB-1] ? IB'(-ay2_r) : IB'(ay2_r);
    mp1 = p1_r[PW-1] ? PW'(-p1_r) : PW'(p1_r);
    mp2 = p2_r[PW-1] ? PW'(-p2_r) : PW'(p2_r);
    sx  = '0;
    sy  = '0;
    ss  = '0;
    sd3_nxt      = '0;
    sd3_nxt.op   = op2_r;
    sd3_nxt.s    = s2_r;
    unique case (op2_r)
      v2a_pkg::OP_ADD: begin
        sx = sat_fn(axw + bxw);
        sy = sat_fn(ayw + byw);
      end
      v2a_pkg::OP_SUB: begin
        sx = sat_fn(axw - bxw);
        sy = sat_fn(ayw - byw);
      end
      v2a_pkg::OP_SCALE: begin
        sx = sat_fn(p1w >>> FRAC_BITS);
        sy = sat_fn(p2w >>> FRAC_BITS);
      end
      v2a_pkg::OP_DOT: begin
        ss = sat_fn((p1w + p2w) >>> FRAC_BITS);
      end
      v2a_pkg::OP_NORM: begin
        sd3_nxt.numx = NB'(mx2) << FRAC_BITS;
        sd3_nxt.numy = NB'(my2) << FRAC_BITS;
        sd3_nxt.negx = ax2_r[IB-1];
        sd3_nxt.negy = ay2_r[IB-1];
      end
      v2a_pkg::OP_CLAMP: begin
        sx = {1'b0, axw};
        sy = {1'b0, ayw};
        sd3_nxt.numx = NB'(mp1);
        sd3_nxt.numy = NB'(mp2);
        sd3_nxt.negx = p1_r[PW-1];
        sd3_nxt.negy = p2_r[PW-1];
      end
      default: begin
      end
    endcase
    sd3_nxt.rx  = sx[31:0];
    sd3_nxt.ry  = sy[31:0];
    sd3_nxt.rs  = ss[31:0];
    sd3_nxt.sat = sx[XW] | sy[XW] | ss[XW];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n3_r  <= q1_r + q2_r;
      sd3_r <= sd3_nxt;
    end
  end

  // square root row
  assign sq_v[0]   = v3_r;
  assign sq_n[0]   = n3_r;
  assign sq_res[0] = '0;
  assign sq_sd[0]  = sd3_r;

  for (genvar i = 0; i < IB; i++) begin : g_sqrt
    v2a_sqrt_cell #(
      .NW      (PW),
      .BIT_POS (PW - 2 - 2 * i),
      .SW      (SQ_SW)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_v     (sq_v[i]),
      .in_n     (sq_n[i]),
      .in_res   (sq_res[i]),
      .in_side  (sq_sd[i]),
      .out_v    (sq_v[i+1]),
      .out_n    (sq_n[i+1]),
      .out_res  (sq_res[i+1]),
      .out_side (sq_sd[i+1])
    );
  end

  // compare stage
  logic [IB:0]  lenx;
  logic         gt_min, gt_s;
  logic [XW:0]  sl;

  always_comb begin
    sq_end  = sq_sd[IB];
    len_end = sq_res[IB][IB-1:0];
    lenx    = {1'b0, len_end};
    gt_min  = lenx > {{(IB + 1 - ML){1'b0}}, min_len_r};
    gt_s    = $signed(lenx) > $signed((IB + 1)'(sq_end.s));
    sl      = sat_fn(XW'(len_end));
    dl_nxt         = '0;
    dl_nxt.rx      = sq_end.rx;
    dl_nxt.ry      = sq_end.ry;
    dl_nxt.rs      = sq_end.rs;
    dl_nxt.sat     = sq_end.sat;
    dl_nxt.negx    = sq_end.negx;
    dl_nxt.negy    = sq_end.negy;
    unique case (sq_end.op)
      v2a_pkg::OP_LEN: begin
        dl_nxt.rs  = sl[31:0];
        dl_nxt.sat = sl[XW];
      end
      v2a_pkg::OP_NORM: begin
        dl_nxt.use_div = gt_min;
      end
      v2a_pkg::OP_CLAMP: begin
        dl_nxt.use_div = gt_s && gt_min;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      len_r <= len_end;
      lnx_r <= sq_end.numx;
      lny_r <= sq_end.numy;
      dl_r  <= dl_nxt;
    end
  end

  // divider row
  assign dv_v[0]    = vl_r;
  assign dv_den[0]  = len_r;
  assign dv_remx[0] = '0;
  assign dv_remy[0] = '0;
  assign dv_nqx[0]  = lnx_r;
  assign dv_nqy[0]  = lny_r;
  assign dv_sd[0]   = dl_r;

  for (genvar j = 0; j < NB; j++) begin : g_div
    v2a_div_cell #(
      .NB (NB),
      .DW (IB),
      .SW (DV_SW)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_v     (dv_v[j]),
      .in_den   (dv_den[j]),
      .in_remx  (dv_remx[j]),
      .in_nqx   (dv_nqx[j]),
      .in_remy  (dv_remy[j]),
      .in_nqy   (dv_nqy[j]),
      .in_side  (dv_sd[j]),
      .out_v    (dv_v[j+1]),
      .out_den  (dv_den[j+1]),
      .out_remx (dv_remx[j+1]),
      .out_nqx  (dv_nqx[j+1]),
      .out_remy (dv_remy[j+1]),
      .out_nqy  (dv_nqy[j+1]),
      .out_side (dv_sd[j+1])
    );
  end

  // sign, saturate and select
  logic signed [XW-1:0] qxw, qyw;
  logic [XW:0]          fx, fy;

  always_comb begin
    dv_end = dv_sd[NB];
    qxw    = XW'(dv_nqx[NB]);
    qyw    = XW'(dv_nqy[NB]);
    if (dv_end.negx) begin
      qxw = -qxw;
    end
    if (dv_end.negy) begin
      qyw = -qyw;
    end
    fx = sat_fn(qxw);
    fy = sat_fn(qyw);
    if (dv_end.use_div) begin
      fin_nxt.rx        = fx[31:0];
      fin_nxt.ry        = fy[31:0];
      fin_nxt.rs        = '0;
      fin_nxt.saturated = fx[XW] | fy[XW];
    end else begin
      fin_nxt.rx        = dv_end.rx;
      fin_nxt.ry        = dv_end.ry;
      fin_nxt.rs        = dv_end.rs;
      fin_nxt.saturated = dv_end.sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en && dv_v[NB]) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && dv_v[NB]) begin
      out_beat_r <= fin_nxt;
    end
  end

endmodule

@@ rtl/v2a_checker.sv @@
// port-level checks for the 2d vector fixed-point unit, bound to the top level
// depends on v2a_pkg and assert_macros.svh
`include "assert_macros.svh"

module v2a_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input v2a_pkg::in_beat_t             in_beat,
  input logic                          out_valid,
  input logic                          out_ready,
  input v2a_pkg::out_beat_t            out_beat,
  input logic                          cfg_valid,
  input logic                          cfg_ready,
  input logic [v2a_pkg::MIN_LEN_W-1:0] cfg_data
);

  logic unused_ok;
  assign unused_ok = in_valid ^ (^in_beat) ^ (^cfg_data);

  // a held result beat keeps its value
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_beat), "out beat dropped or changed while stalled")

  // input only backs up behind a stalled result
  `ASSERT_IMPL(a_in_stall, clk, rst_n, !in_ready, out_valid && !out_ready, "in_ready low without output stall")

  // config writes are never refused
  `ASSERT_IMPL(a_cfg_rdy, clk, rst_n, cfg_valid, cfg_ready, "cfg write refused")

endmodule

bind vec2_fixed_point_alu_unit v2a_checker u_v2a_checker (.*);

@@ tb/tb_vec2_fixed_point_alu_unit.sv @@
// self-checking testbench of the 2d vector fixed-point unit: directed and random beats,
// independent predictor in a scoreboard class, random sender bursts and receiver stalls
// depends on v2a_pkg and vec2_fixed_point_alu_unit
module tb_vec2_fixed_point_alu_unit;

  localparam int FB = 16;
  localparam longint WMAX = 64'sh7FFFFFFF;
  localparam longint WMIN = -64'sh80000000;

  class vec_scoreboard;
    v2a_pkg::out_beat_t pending[$];
    logic [15:0] min_len;
    int errors;

    function new();
      min_len = v2a_pkg::MIN_LEN_RST;
      errors = 0;
    endfunction

    function longint clip(longint v, ref bit flag);
      if (v > WMAX) begin
        flag = 1;
        return WMAX;
      end
      if (v < WMIN) begin
        flag = 1;
        return WMIN;
      end
      return v;
    endfunction

    function longint fl_shift(longint v);
      return v >>> FB;
    endfunction

    function longint unsigned root(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function longint quot(longint num, longint unsigned den);
      longint unsigned m, q;
      m = (num < 0) ? longint'(-num) : num;
      q = m / den;
      return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function void note_request(v2a_pkg::in_beat_t b);
      longint ax, ay, bx, by, s, rx, ry, rs, p1, p2, h1, h2;
      longint unsigned mx, my, len;
      bit flag;
      v2a_pkg::out_beat_t o;
      ax = b.ax; ay = b.ay; bx = b.bx; by = b.by; s = b.scalar_in;
      rx = 0; ry = 0; rs = 0; flag = 0;
      mx = (ax < 0) ? -ax : ax;
      my = (ay < 0) ? -ay : ay;
      len = root(mx * mx + my * my);
      case (b.req_type)
        v2a_pkg::OP_ADD: begin
          rx = clip(ax + bx, flag);
          ry = clip(ay + by, flag);
        end
        v2a_pkg::OP_SUB: begin
          rx = clip(ax - bx, flag);
          ry = clip(ay - by, flag);
        end
        v2a_pkg::OP_SCALE: begin
          rx = clip(fl_shift(ax * s), flag);
          ry = clip(fl_shift(ay * s), flag);
        end
        v2a_pkg::OP_DOT: begin
          p1 = ax * bx;
          p2 = ay * by;
          h1 = fl_shift(p1);
          h2 = fl_shift(p2);
          rs = clip(h1 + h2 + ((p1 - (h1 <<< FB) + p2 - (h2 <<< FB)) >>> FB), flag);
        end
        v2a_pkg::OP_LEN: rs = clip(longint'(len), flag);
        v2a_pkg::OP_NORM: begin
          if (len > min_len) begin
            rx = clip(quot(ax <<< FB, len), flag);
            ry = clip(quot(ay <<< FB, len), flag);
          end
        end
        v2a_pkg::OP_CLAMP: begin
          if (longint'(len) > s && len > min_len) begin
            rx = clip(quot(ax * s, len), flag);
            ry = clip(quot(ay * s, len), flag);
          end else begin
            rx = ax;
            ry = ay;
          end
        end
        default: ;
      endcase
      o.rx = rx[31:0];
      o.ry = ry[31:0];
      o.rs = rs[31:0];
      o.saturated = flag;
      pending.push_back(o);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      errors++;
    endtask

    task check_result(v2a_pkg::out_beat_t got);
      v2a_pkg::out_beat_t w;
      if (pending.size() == 0) begin
        report("unexpected beat", got.rs, 0);
        return;
      end
      w = pending.pop_front();
      if (got.rx !== w.rx) report("rx", got.rx, w.rx);
      if (got.ry !== w.ry) report("ry", got.ry, w.ry);
      if (got.rs !== w.rs) report("rs", got.rs, w.rs);
      if (got.saturated !== w.saturated) report("saturated", got.saturated, w.saturated);
    endtask
  endclass

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0, cfg_valid = 0, cfg_ready;
  v2a_pkg::in_beat_t in_beat = '0;
  v2a_pkg::out_beat_t out_beat;
  logic [15:0] cfg_data = '0;
  vec_scoreboard sb = new();
  int stall_mode = 0;

  vec2_fixed_point_alu_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_beat(in_beat),
    .out_valid(out_valid), .out_ready(out_ready), .out_beat(out_beat),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_beat);
  end

  // receiver stall pattern, changing mode every so often
  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready <= 1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ($urandom_range(0, 1) != 0);
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // valid stays high after the beat; the caller drops it when it idles
  task send_request(v2a_pkg::in_beat_t b);
    in_valid <= 1;
    in_beat <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_request(b);
    @(negedge clk);
  endtask

  // back-to-back beats keep valid high across the accept edge
  task send_burst(int n, bit directed_mix);
    v2a_pkg::in_beat_t b;
    for (int i = 0; i < n; i++) begin
      b = make_random();
      in_valid <= 1;
      in_beat <= b;
      do @(posedge clk); while (!in_ready);
      sb.note_request(b);
      @(negedge clk);
    end
  endtask

  function logic [31:0] rnd_word();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      1: return $urandom_range(0, 1) ? 32'($urandom_range(0, 16)) : -32'($urandom_range(0, 16));
      2: return 32'(int'($urandom_range(0, 32'h0003FFFF)) - 32'h00020000);
      3: return 32'(int'($urandom_range(0, 32'h07FFFFFF)) - 32'h04000000);
      default: return $urandom;
    endcase
  endfunction

  function v2a_pkg::in_beat_t make_random();
    v2a_pkg::in_beat_t b;
    b.req_type = ($urandom_range(0, 40) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
    b.ax = rnd_word(); b.ay = rnd_word(); b.bx = rnd_word(); b.by = rnd_word();
    b.scalar_in = rnd_word();
    return b;
  endfunction

  function v2a_pkg::in_beat_t mk(logic [2:0] op, int ax, int ay, int bx, int by, int s);
    v2a_pkg::in_beat_t b;
    b.req_type = op; b.ax = ax; b.ay = ay; b.bx = bx; b.by = by; b.scalar_in = s;
    return b;
  endfunction

  task drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (110) @(posedge clk);
    @(negedge clk);
  endtask

  task write_min_len(logic [15:0] v);
    cfg_valid <= 1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.min_len = v;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  initial begin
    logic [15:0] settings[4];
    settings = '{16'd0, 16'hFFFF, 16'd7, 16'h1234};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    send_request(mk(v2a_pkg::OP_ADD, 32'h7FFFFFFF, 32'h80000000, 1, -1, 0));
    send_request(mk(v2a_pkg::OP_SUB, 32'h80000000, 32'h7FFFFFFF, 1, -1, 0));
    send_request(mk(v2a_pkg::OP_SCALE, 32'h00030000, -32'h00018000, 0, 0, 32'h00020000));
    send_request(mk(v2a_pkg::OP_SCALE, 32'h7FFFFFFF, 32'h80000000, 0, 0, 32'h80000000));
    send_request(mk(v2a_pkg::OP_DOT, 32'h80000000, 32'h80000000, 32'h80000000,
                    32'h80000000, 0));
    send_request(mk(v2a_pkg::OP_DOT, -1, 3, 1, -5, 0));
    send_request(mk(v2a_pkg::OP_LEN, 32'h80000000, 32'h80000000, 0, 0, 0));
    send_request(mk(v2a_pkg::OP_LEN, 32'h00030000, 32'h00040000, 0, 0, 0));
    send_request(mk(v2a_pkg::OP_NORM, 3, 4, 0, 0, 0));
    send_request(mk(v2a_pkg::OP_NORM, 5, 5, 0, 0, 0));
    send_request(mk(v2a_pkg::OP_NORM, 32'h00030000, -32'h00040000, 0, 0, 0));
    send_request(mk(v2a_pkg::OP_NORM, 32'h80000000, 32'h7FFFFFFF, 0, 0, 0));
    send_request(mk(v2a_pkg::OP_CLAMP, 32'h00030000, 32'h00040000, 0, 0, 32'h00010000));
    send_request(mk(v2a_pkg::OP_CLAMP, 32'h00030000, 32'h00040000, 0, 0, 32'h000A0000));
    send_request(mk(v2a_pkg::OP_CLAMP, 32'h00030000, 32'h00040000, 0, 0, -32'h00010000));
    send_request(mk(v2a_pkg::OP_CLAMP, 2, 2, 0, 0, 0));
    send_request(mk(v2a_pkg::OP_CLAMP, 32'h80000000, 32'h80000000, 0, 0, 32'h80000000));
    send_request(mk(3'd7, 32'h12345678, -5, 6, 7, 8));
    send_request(mk(v2a_pkg::OP_ADD, 32'hFFFFFFFF, 0, 32'hFFFFFFFF, 0, 32'hFFFFFFFF));
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      int sent;
      int gap;
      write_min_len(settings[ph]);
      send_request(mk(v2a_pkg::OP_NORM, 32'h00001000, 0, 0, 0, 0));
      send_request(mk(v2a_pkg::OP_CLAMP, 32'h00001000, 0, 0, 0, 0));
      sent = 0;
      while (sent < 300) begin
        int n;
        n = $urandom_range(1, 40);
        send_burst(n, 0);
        sent += n;
        if ($urandom_range(0, 9) == 0) begin
          in_valid <= 0;
          while (sb.pending.size() != 0) @(posedge clk);
          @(negedge clk);
        end else begin
          gap = $urandom_range(0, 6);
          if (gap != 0) begin
            in_valid <= 0;
            repeat (gap) @(negedge clk);
          end
        end
      end
      drain();
    end
    if (sb.errors == 0 && sb.pending.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
